/* src/bse_pkg.sv */
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants of the bucket sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned CAPACITY_DEF = 64;

    // input beat: one value of the set
    typedef struct packed {
        logic [DATA_W-1:0] sample_value;
        logic              end_of_set;
    } t_in_beat;

    // output beat: next value in ascending order
    typedef struct packed {
        logic [DATA_W-1:0] sorted_value;
        logic              final_flag;
    } t_out_beat;

    // sequencer commands to every cell of the chain
    typedef struct packed {
        logic insert;   // place the key in order, upper cells move up
        logic shift;    // every cell takes its upper neighbor
    } t_chain_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              valid;
        logic              le;      // valid and value <= key
    } t_cell_view;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

/* src/bse_cell.sv */
// ----------------------------------------------------------------------------
// bse_cell
// One slot of the sorting chain: holds one value, compares it with the
// incoming key and takes the key or a neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bse_pkg::t_chain_ctl         i_ctl,
    input  wire logic [bse_pkg::DATA_W-1:0]  i_key,
    input  wire bse_pkg::t_cell_view         i_lower,
    input  wire bse_pkg::t_cell_view         i_upper,
    output bse_pkg::t_cell_view              o_view
);

    logic [bse_pkg::DATA_W-1:0] r_value, n_value;
    logic                       r_valid, n_valid;
    logic                       w_le;

    assign w_le = r_valid && (r_value <= i_key);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_value = i_upper.value;
            n_valid = i_upper.valid;
        end else if (i_ctl.insert && !w_le) begin
            // equal values stay below the key: arrival order kept
            // above the insertion point a cell takes its lower neighbor, empty or not
            n_value = i_lower.le ? i_key : i_lower.value;
            n_valid = i_lower.le || i_lower.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_view.value = r_value;
    assign o_view.valid = r_valid;
    assign o_view.le    = w_le;

endmodule

`default_nettype wire

/* src/bse_ctrl.sv */
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: load phase counts stored values, drain phase hands them out.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ctrl #(
    parameter int unsigned CAPACITY = bse_pkg::CAPACITY_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_last,
    input  wire logic            i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output logic                 o_final,
    output bse_pkg::t_chain_ctl  o_ctl
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    bse_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_room;
    logic             w_one_left;

    assign w_room     = r_cnt < CNT_W'(CAPACITY);
    assign w_one_left = r_cnt == CNT_W'(1);
    assign w_in_acc   = i_in_valid && (r_state == bse_pkg::ST_LOAD);
    assign w_out_acc  = (r_state == bse_pkg::ST_DRAIN) && !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bse_pkg::ST_LOAD: begin
                if (w_in_acc && i_in_last) begin
                    n_state = bse_pkg::ST_DRAIN;
                end
            end
            bse_pkg::ST_DRAIN: begin
                if (w_out_acc && w_one_left) begin
                    n_state = bse_pkg::ST_LOAD;
                end
            end
            default: n_state = bse_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall   = 1'b1;
        o_out_valid  = 1'b0;
        o_ctl.insert = 1'b0;
        o_ctl.shift  = 1'b0;
        unique case (r_state)
            bse_pkg::ST_LOAD: begin
                o_in_stall   = 1'b0;
                o_ctl.insert = w_in_acc && w_room;   // overflow values dropped
            end
            bse_pkg::ST_DRAIN: begin
                o_out_valid = 1'b1;
                o_ctl.shift = w_out_acc;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign o_final = w_one_left;

    always_comb begin
        n_cnt = r_cnt;
        if (o_ctl.insert) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (o_ctl.shift) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bse_pkg::ST_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* src/bucket_sort_engine.sv */
// ----------------------------------------------------------------------------
// bucket_sort_engine
// Sorts a set of unsigned Q16.16 values and returns it in ascending order.
// ----------------------------------------------------------------------------
// Load: one beat per cycle, each value placed in order on arrival.
// Drain: starts the cycle after the end-of-set beat, one beat per cycle
//   without stall.
// Input is stalled during drain; the drain rate is set by the chain's shift.
// Reset (synchronous, active low) empties the chain and returns to load.
// ----------------------------------------------------------------------------
`default_nettype none

module bucket_sort_engine #(
    parameter int unsigned CAPACITY = bse_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire bse_pkg::t_in_beat  i_in_beat,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output bse_pkg::t_out_beat      o_out_beat,
    input  wire logic               i_out_stall
);

    // The bucket split by floor(value*10/(max+1.0)) is monotone in the value,
    // so sorted buckets laid end to end are exactly the sorted set. The chain
    // keeps that order directly: cell 0 holds the smallest value.

    bse_pkg::t_chain_ctl w_ctl;
    logic                w_final;

    // view[k] is the lower neighbor of cell k; view[k+1] is cell k itself
    bse_pkg::t_cell_view w_view [CAPACITY+1];
    bse_pkg::t_cell_view w_top;

    bse_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_beat.end_of_set),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_final     (w_final),
        .o_ctl       (w_ctl)
    );

    // boundary below cell 0: behaves as a value <= any key
    assign w_view[0].value = '0;
    assign w_view[0].valid = 1'b1;
    assign w_view[0].le    = 1'b1;

    // boundary above the last cell: empty slot shifts in
    assign w_top.value = '0;
    assign w_top.valid = 1'b0;
    assign w_top.le    = 1'b0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        bse_pkg::t_cell_view w_upper;
        if (k == CAPACITY - 1) begin : g_last
            assign w_upper = w_top;
        end else begin : g_mid
            assign w_upper = w_view[k+2];
        end
        bse_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_key   (i_in_beat.sample_value),
            .i_lower (w_view[k]),
            .i_upper (w_upper),
            .o_view  (w_view[k+1])
        );
    end

    // cell 0 is the output register
    assign o_out_beat.sorted_value = w_view[1].value;
    assign o_out_beat.final_flag   = w_final;

endmodule

`default_nettype wire

/* src/bse_checker.sv */
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks of the sort engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire bse_pkg::t_in_beat  i_in_beat,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire bse_pkg::t_out_beat o_out_beat,
    input wire logic               i_out_stall
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled output beat changed");

    // no input taken while results are pending
    a_drain_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted during drain");

    // end-of-set beat starts the drain
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_beat.end_of_set) |=> o_out_valid)
        else $error("no output after end of set");

    // values come out in ascending order within a set
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_beat.final_flag) |=>
            (o_out_valid && (o_out_beat.sorted_value >= $past(o_out_beat.sorted_value))))
        else $error("output not ascending");

endmodule

bind bucket_sort_engine bse_checker u_bse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_beat   (i_in_beat),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_beat  (o_out_beat),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

/* tb/bucket_sort_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bucket_sort_engine_tb
// Self-checking bench: feeds sets of Q16.16 values, checks the sorted stream.
// ----------------------------------------------------------------------------
// A clocked driver pops beats from a pending queue that the stimulus block
// fills. Each accepted beat goes through a local bucket + insertion sort
// model, which queues the expected sorted beats when the set closes. A clocked
// monitor compares each accepted output beat with the oldest expected beat.
// Both sides idle at random, with a quiet window and one long output hold.
// ----------------------------------------------------------------------------

module bucket_sort_engine_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int CAP          = bse_pkg::CAPACITY_DEF;
    localparam int NBINS        = 10;           // bucket count of the sort model
    localparam int RANDOM_BEATS = 225;
    localparam int IDLE_PCT     = 15;
    localparam int HOLD_CYCLES  = 300;          // long receiver hold-off
    localparam int HOLD_AT_BEAT = 40;           // beats sent before the hold
    localparam int CALM_FROM    = 150;          // no idling on either side
    localparam int CALM_TO      = 230;          //   between these beat counts
    localparam int DRAIN_SLACK  = 2 * CAP + 16;
    localparam int LIMIT_CYCLES = 200000;

    // one pending beat; wait_empty holds it back until every result is in
    typedef struct packed {
        logic              wait_empty;
        bse_pkg::t_in_beat beat;
    } t_pending;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    bse_pkg::t_in_beat  in_beat   = '0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    bse_pkg::t_out_beat o_out_beat;

    t_pending           pending_beats[$];
    bse_pkg::t_out_beat sorted_due[$];
    bse_pkg::t_out_beat due;
    int                 beats_sent = 0;
    int                 fail_count = 0;
    int                 hold_left  = 0;
    bit                 hold_done  = 1'b0;
    logic               calm;

    // model state: values of the open set and their running maximum
    logic [31:0] set_vals[CAP];
    int          set_len  = 0;
    logic [31:0] set_peak = '0;

    bucket_sort_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_beat  (in_beat),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_beat (o_out_beat),
        .i_out_stall(out_stall)
    );

    initial forever #(CLK_PERIOD / 2) i_clk = ~i_clk;

    assign calm = (beats_sent >= CALM_FROM) && (beats_sent < CALM_TO);

    // ------------------------------------------------------------------------
    // Sort model. Stores the value (dropped once the set is full), and on the
    // closing beat spreads the set over the buckets by
    // value * NBINS / (peak + 1.0), insertion-sorts each bucket, and queues
    // the buckets in order. The last queued beat carries the final flag.
    // ------------------------------------------------------------------------
    task automatic bucket_sort_sample(input bse_pkg::t_in_beat b);
        logic [32:0]        span;
        logic [63:0]        bin_idx;
        logic [31:0]        bin_cells[NBINS][CAP];
        int                 bin_len[NBINS];
        logic [31:0]        key;
        int                 pos;
        int                 emitted;
        bse_pkg::t_out_beat res;
        if (set_len < CAP) begin
            set_vals[set_len] = b.sample_value;
            set_len++;
            if (b.sample_value > set_peak)
                set_peak = b.sample_value;
        end
        if (b.end_of_set) begin
            foreach (bin_len[k])
                bin_len[k] = 0;
            span = {1'b0, set_peak} + 33'd65536;
            for (int i = 0; i < set_len; i++) begin
                bin_idx = (64'(set_vals[i]) * NBINS) / 64'(span);
                if (bin_idx >= NBINS)
                    bin_idx = NBINS - 1;  // guard only; value <= peak keeps it in range
                bin_cells[bin_idx][bin_len[bin_idx]] = set_vals[i];
                bin_len[bin_idx]++;
            end
            emitted = 0;
            for (int k = 0; k < NBINS; k++) begin
                for (int i = 1; i < bin_len[k]; i++) begin
                    key = bin_cells[k][i];
                    pos = i;
                    while (pos > 0 && bin_cells[k][pos-1] > key) begin
                        bin_cells[k][pos] = bin_cells[k][pos-1];
                        pos--;
                    end
                    bin_cells[k][pos] = key;
                end
                for (int i = 0; i < bin_len[k]; i++) begin
                    res.sorted_value = bin_cells[k][i];
                    res.final_flag   = (emitted == set_len - 1);
                    sorted_due.push_back(res);
                    emitted++;
                end
            end
            set_len  = 0;
            set_peak = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic [31:0] value, input logic last,
                             input logic wait_empty);
        t_pending p;
        p.wait_empty        = wait_empty;
        p.beat.sample_value = value;
        p.beat.end_of_set   = last;
        pending_beats.push_back(p);
    endtask

    // value flavors: full range, small, near the top, few distinct (duplicates)
    function automatic logic [31:0] pick_value(input int flavor);
        case (flavor)
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0003_FFFF);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 65535);
            default: return $urandom_range(0, 3) * 32'h5555_5555;
        endcase
    endfunction

    task automatic push_set(input int n, input logic wait_empty);
        int flavor;
        flavor = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            push_beat(pick_value(flavor), i == n - 1, wait_empty && i == 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: a beat stays put while stalled; a new one is chosen only when
    // the bus is free. Beats flagged wait_empty go out once nothing is due.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                bucket_sort_sample(in_beat);
                beats_sent <= beats_sent + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_beats.size() != 0
                        && (calm || $urandom_range(0, 99) >= IDLE_PCT)
                        && !(pending_beats[0].wait_empty && sorted_due.size() != 0)) begin
                    in_beat  <= pending_beats[0].beat;
                    in_valid <= 1'b1;
                    void'(pending_beats.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks accepted output beats and drives the output stall.
    // One long hold-off holds the engine in its drain, with its input stalled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (sorted_due.size() == 0) begin
                    $display("%0t: unexpected beat value=%h final=%b",
                             $time, o_out_beat.sorted_value, o_out_beat.final_flag);
                    fail_count++;
                end else begin
                    due = sorted_due.pop_front();
                    if (o_out_beat.sorted_value !== due.sorted_value) begin
                        $display("%0t: sorted_value expected %h actual %h",
                                 $time, due.sorted_value, o_out_beat.sorted_value);
                        fail_count++;
                    end
                    if (o_out_beat.final_flag !== due.final_flag) begin
                        $display("%0t: final_flag expected %b actual %b",
                                 $time, due.final_flag, o_out_beat.final_flag);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int n;
        int set_no;
        int fed;

        // directed: lone zero, lone max, extremes with duplicates and 1.0,
        // all equal, wide spread, all zero (peak stays zero)
        push_beat(32'h0000_0000, 1'b1, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_beat(32'h0000_0000, 1'b0, 1'b0);
        push_beat(32'h0001_0000, 1'b0, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_beat(32'h0000_0000, 1'b0, 1'b0);
        push_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
        push_beat(32'h0000_FFFF, 1'b1, 1'b0);
        repeat (4) push_beat(32'h0000_0003, 1'b0, 1'b0);
        push_beat(32'h0000_0003, 1'b1, 1'b0);
        push_beat(32'h8000_0000, 1'b0, 1'b0);
        push_beat(32'h0000_0001, 1'b0, 1'b0);
        push_beat(32'hFFFF_FFFE, 1'b0, 1'b0);
        push_beat(32'h5555_AAAA, 1'b1, 1'b0);
        push_beat(32'h0000_0000, 1'b0, 1'b0);
        push_beat(32'h0000_0000, 1'b1, 1'b0);

        // random sets, mostly small; one exactly full, one overflowing set
        // whose closing beat is itself dropped; set 2 waits for a drained bus
        set_no = 0;
        fed    = 0;
        while (fed < RANDOM_BEATS) begin
            case (set_no)
                3:       n = CAP;
                6:       n = CAP + 3;
                default: n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                         : $urandom_range(1, 16);
            endcase
            push_set(n, set_no == 2 || $urandom_range(0, 9) == 0);
            fed += n;
            set_no++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || in_valid)
            @(posedge i_clk);
        while (sorted_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
src/bse_pkg.sv
src/bse_cell.sv
src/bse_ctrl.sv
src/bucket_sort_engine.sv
src/bse_checker.sv
tb/bucket_sort_engine_tb.sv
